>>> rtl/prms_pkg.sv
// ----------------------------------------------------------------------------
// prms_pkg
// shared types, codes and constants of the planar robot motion step
// ----------------------------------------------------------------------------
`default_nettype none

package prms_pkg;

  typedef logic [1:0] req_t;

  localparam req_t REQ_CMD  = 2'd0;
  localparam req_t REQ_TICK = 2'd1;
  localparam req_t REQ_POSE = 2'd2;

  localparam logic [2:0] CFG_MAX_SPEED      = 3'd0;
  localparam logic [2:0] CFG_MAX_TURN_RATE  = 3'd1;
  localparam logic [2:0] CFG_MAX_ACCEL      = 3'd2;
  localparam logic [2:0] CFG_MAX_TURN_ACCEL = 3'd3;
  localparam logic [2:0] CFG_TIMEOUT        = 3'd4;

  localparam logic [24:0] AGE_MAX        = 25'h1FFFFFF;
  localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
  localparam logic [32:0] CORDIC_X0      = 33'd652032874;

  typedef struct packed {
    logic               done;
    logic signed [18:0] cos16;
    logic signed [18:0] sin16;
  } cordic_res_t;

  function automatic logic [29:0] cordic_atan(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> rtl/planar_robot_motion_step.sv
// ----------------------------------------------------------------------------
// planar_robot_motion_step
// unicycle robot model with slew-limited speed and turn rate
// ----------------------------------------------------------------------------
// items enter on the in_ channel (valid/ready); each returns one state item
// on the out_ channel. a command stores the target rates and restarts the
// command age, a set-pose item places the robot, a tick moves it.
// command and set-pose items go straight to S_DONE, from which the result is
// loaded into the output register, raising out_valid, once it is free. a tick
// steps through S_T1 to S_T12 and waits in S_T10 for the cordic, which runs
// one micro-rotation per cycle beside the shared 35x19 multiplier that does
// the slew, position and heading products. in_ready is high only while no
// item is in work, one item at a time. the result sits in an output register:
// the next item may be taken while it waits, but a finished item holds until
// out_ready frees the register. configuration writes on cfg_ are always taken;
// write only while idle. reset clears the pose and rates, restores register
// defaults and marks no command received; out_valid is low after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module planar_robot_motion_step #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire  [1:0]          in_req_type,
  input  wire  signed [15:0]  in_target_speed,
  input  wire  signed [15:0]  in_target_turn_rate,
  input  wire  [17:0]         in_time_step,
  input  wire  signed [31:0]  in_set_x,
  input  wire  signed [31:0]  in_set_y,
  input  wire  [15:0]         in_set_heading,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic signed [31:0]  out_pos_x,
  output logic signed [31:0]  out_pos_y,
  output logic [15:0]         out_heading,
  output logic signed [15:0]  out_speed,
  output logic signed [15:0]  out_turn_rate,
  output logic                out_command_live,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire  [2:0]          cfg_index,
  input  wire  [23:0]         cfg_data
);
  import prms_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_T1   = 4'd1;
  localparam logic [3:0] S_T2   = 4'd2;
  localparam logic [3:0] S_T3   = 4'd3;
  localparam logic [3:0] S_T4   = 4'd4;
  localparam logic [3:0] S_T5   = 4'd5;
  localparam logic [3:0] S_T6   = 4'd6;
  localparam logic [3:0] S_T7   = 4'd7;
  localparam logic [3:0] S_T8   = 4'd8;
  localparam logic [3:0] S_T9   = 4'd9;
  localparam logic [3:0] S_T10  = 4'd10;
  localparam logic [3:0] S_T11  = 4'd11;
  localparam logic [3:0] S_T12  = 4'd12;
  localparam logic [3:0] S_DONE = 4'd13;

  function automatic logic signed [15:0] slew_f(
    input logic signed [15:0] cur,
    input logic signed [15:0] goal,
    input logic [12:0]        amt,
    input logic [14:0]        lim
  );
    logic signed [17:0] delta, mag, v, amt_s, lim_s;
    delta = 18'(goal) - 18'(cur);
    amt_s = signed'({5'b0, amt});
    lim_s = signed'({3'b0, lim});
    mag   = delta[17] ? -delta : delta;
    if (mag < amt_s) begin
      v = 18'(goal);
    end else if (delta > 18'sd0) begin
      v = 18'(cur) + amt_s;
    end else begin
      v = 18'(cur) - amt_s;
    end
    if (v > lim_s) begin
      v = lim_s;
    end else if (v < -lim_s) begin
      v = -lim_s;
    end
    return v[15:0];
  endfunction

  logic [3:0]         state_r, state_nxt;
  logic [14:0]        max_speed_r, max_accel_r, max_turn_accel_r;
  logic [13:0]        max_turn_rate_r;
  logic [23:0]        timeout_r;
  logic signed [15:0] speed_r, speed_nxt, turn_r, turn_nxt;
  logic signed [15:0] goal_s_r, goal_s_nxt, goal_t_r, goal_t_nxt;
  logic signed [31:0] px_r, px_nxt, py_r, py_nxt;
  logic [15:0]        hd_r, hd_nxt;
  logic [24:0]        age_r, age_nxt;
  logic [17:0]        d_r, d_nxt;
  logic [12:0]        amt_r, amt_nxt;
  logic signed [33:0] p_r, p_nxt, t_r, t_nxt;
  logic signed [63:0] acc_r, acc_nxt;
  logic signed [34:0] mul_a;
  logic signed [18:0] mul_b;
  logic signed [53:0] prod_r;
  logic signed [63:0] prod_x, hsum, rsum;
  logic [25:0]        age_sum;
  logic               take, load_out, cordic_start;
  cordic_res_t        cres;

  prms_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .angle (hd_r),
    .res   (cres)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign take      = in_valid && in_ready;
  assign prod_x    = 64'(prod_r);
  assign hsum      = acc_r + 64'sh0000_8000_0000_0000;
  assign rsum      = prod_x + 64'sh0000_0000_8000_0000;
  assign age_sum   = 26'(age_r) + 26'(in_time_step);
  assign load_out  = (state_r == S_DONE) && (!out_valid || out_ready);
  assign cordic_start = take && (in_req_type == REQ_TICK);

  // shared multiplier, operands chosen by step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_T1: begin
        mul_a = 35'(max_accel_r);
        mul_b = signed'({1'b0, d_r});
      end
      S_T2: begin
        mul_a = 35'(max_turn_accel_r);
        mul_b = signed'({1'b0, d_r});
      end
      S_T4: begin
        mul_a = 35'(speed_r);
        mul_b = signed'({1'b0, d_r});
      end
      S_T5: begin
        mul_a = 35'(turn_r);
        mul_b = signed'({1'b0, d_r});
      end
      S_T7: begin
        mul_a = 35'(t_r);
        mul_b = signed'({4'b0, INV_TWO_PI_Q32[14:0]});
      end
      S_T8: begin
        mul_a = 35'(t_r);
        mul_b = signed'({4'b0, INV_TWO_PI_Q32[29:15]});
      end
      S_T10: begin
        mul_a = 35'(p_r);
        mul_b = cres.cos16;
      end
      S_T11: begin
        mul_a = 35'(p_r);
        mul_b = cres.sin16;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    speed_nxt  = speed_r;
    turn_nxt   = turn_r;
    goal_s_nxt = goal_s_r;
    goal_t_nxt = goal_t_r;
    px_nxt     = px_r;
    py_nxt     = py_r;
    hd_nxt     = hd_r;
    age_nxt    = age_r;
    d_nxt      = d_r;
    amt_nxt    = amt_r;
    p_nxt      = p_r;
    t_nxt      = t_r;
    acc_nxt    = acc_r;
    case (state_r)
      S_IDLE: begin
        if (take) begin
          state_nxt = S_DONE;
          case (in_req_type)
            REQ_CMD: begin
              goal_s_nxt = in_target_speed;
              goal_t_nxt = in_target_turn_rate;
              age_nxt    = '0;
            end
            REQ_TICK: begin
              state_nxt = S_T1;
              d_nxt     = in_time_step;
              age_nxt   = age_sum[25] ? AGE_MAX : age_sum[24:0];
              if (age_nxt > 25'(timeout_r)) begin
                goal_s_nxt = '0;
                goal_t_nxt = '0;
              end
            end
            REQ_POSE: begin
              px_nxt     = in_set_x;
              py_nxt     = in_set_y;
              hd_nxt     = in_set_heading;
              speed_nxt  = '0;
              turn_nxt   = '0;
              goal_s_nxt = '0;
              goal_t_nxt = '0;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_T1: state_nxt = S_T2;
      S_T2: begin
        amt_nxt   = prod_r[32:20];
        state_nxt = S_T3;
      end
      S_T3: begin
        speed_nxt = slew_f(speed_r, goal_s_r, amt_r, max_speed_r);
        turn_nxt  = slew_f(turn_r, goal_t_r, prod_r[32:20], {1'b0, max_turn_rate_r});
        state_nxt = S_T4;
      end
      S_T4: state_nxt = S_T5;
      S_T5: begin
        p_nxt     = prod_r[33:0];
        state_nxt = S_T6;
      end
      S_T6: begin
        t_nxt     = prod_r[33:0];
        state_nxt = S_T7;
      end
      S_T7: state_nxt = S_T8;
      S_T8: begin
        acc_nxt   = prod_x;
        state_nxt = S_T9;
      end
      S_T9: begin
        acc_nxt   = acc_r + (prod_x <<< 15);
        state_nxt = S_T10;
      end
      S_T10: begin
        if (cres.done) begin
          hd_nxt    = hd_r + hsum[63:48];
          state_nxt = S_T11;
        end
      end
      S_T11: begin
        px_nxt    = px_r + rsum[63:32];
        state_nxt = S_T12;
      end
      S_T12: begin
        py_nxt    = py_r + rsum[63:32];
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      out_valid        <= 1'b0;
      max_speed_r      <= 15'd1638;
      max_turn_rate_r  <= 14'd4096;
      max_accel_r      <= 15'd4096;
      max_turn_accel_r <= 15'd4096;
      timeout_r        <= 24'd209715;
      speed_r          <= '0;
      turn_r           <= '0;
      goal_s_r         <= '0;
      goal_t_r         <= '0;
      px_r             <= '0;
      py_r             <= '0;
      hd_r             <= '0;
      age_r            <= AGE_MAX;
    end else begin
      state_r  <= state_nxt;
      speed_r  <= speed_nxt;
      turn_r   <= turn_nxt;
      goal_s_r <= goal_s_nxt;
      goal_t_r <= goal_t_nxt;
      px_r     <= px_nxt;
      py_r     <= py_nxt;
      hd_r     <= hd_nxt;
      age_r    <= age_nxt;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_index)
          CFG_MAX_SPEED:      max_speed_r      <= cfg_data[14:0];
          CFG_MAX_TURN_RATE:  max_turn_rate_r  <= cfg_data[13:0];
          CFG_MAX_ACCEL:      max_accel_r      <= cfg_data[14:0];
          CFG_MAX_TURN_ACCEL: max_turn_accel_r <= cfg_data[14:0];
          CFG_TIMEOUT:        timeout_r        <= cfg_data;
          default: ;
        endcase
      end
    end
    d_r    <= d_nxt;
    amt_r  <= amt_nxt;
    p_r    <= p_nxt;
    t_r    <= t_nxt;
    acc_r  <= acc_nxt;
    prod_r <= mul_a * mul_b;
    if (load_out) begin
      out_pos_x        <= px_r;
      out_pos_y        <= py_r;
      out_heading      <= hd_r;
      out_speed        <= speed_r;
      out_turn_rate    <= turn_r;
      out_command_live <= (age_r <= 25'(timeout_r));
    end
  end

endmodule

`default_nettype wire

>>> rtl/prms_cordic.sv
// ----------------------------------------------------------------------------
// prms_cordic
// iterative rotation-mode cordic, one micro-rotation per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module prms_cordic #(
  parameter int STEPS = 16
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  input  wire  [15:0]           angle,
  output prms_pkg::cordic_res_t res
);
  import prms_pkg::*;

  logic signed [32:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [33:0] z_r, z_nxt;
  logic [4:0]         step_r, step_nxt;
  logic               run_r, run_nxt, done_r, done_nxt, flip_r, flip_nxt;
  logic               fold;
  logic signed [32:0] dx, dy, xs, ys;
  logic signed [33:0] at;
  logic signed [18:0] cr, sr;

  assign fold = angle[15] ^ angle[14];
  assign dx   = y_r >>> step_r;
  assign dy   = x_r >>> step_r;
  assign at   = 34'(cordic_atan(step_r));

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    step_nxt = step_r;
    run_nxt  = run_r;
    done_nxt = done_r;
    flip_nxt = flip_r;
    if (start) begin
      x_nxt    = CORDIC_X0;
      y_nxt    = '0;
      z_nxt    = 34'(signed'({angle[15] ^ fold, angle[14:0], 16'h0000}));
      step_nxt = '0;
      run_nxt  = 1'b1;
      done_nxt = 1'b0;
      flip_nxt = fold;
    end else if (run_r) begin
      if (!z_r[33]) begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + at;
      end
      step_nxt = step_r + 5'd1;
      if (step_r == 5'(STEPS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    step_r <= step_nxt;
    flip_r <= flip_nxt;
  end

  // round to q.16
  assign xs = x_r + 33'sd8192;
  assign ys = y_r + 33'sd8192;
  assign cr = xs[32:14];
  assign sr = ys[32:14];

  assign res.done  = done_r;
  assign res.cos16 = flip_r ? -cr : cr;
  assign res.sin16 = flip_r ? -sr : sr;

endmodule

`default_nettype wire

>>> rtl/prms_checker.sv
// ----------------------------------------------------------------------------
// prms_checker
// port-level checks of the planar robot motion step
// ----------------------------------------------------------------------------
`default_nettype none

module prms_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [31:0] out_pos_x,
  input wire [15:0] out_heading
);

  // one item in work at a time
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // reset leaves the block idle with nothing to show
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pos_x) && $stable(out_heading))
    else $error("stalled result changed");

endmodule

bind planar_robot_motion_step prms_checker u_prms_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_pos_x   (out_pos_x),
  .out_heading (out_heading)
);

`default_nettype wire
